>>> sv/moe_route_group_by_expert_defines.svh
// Assertion macros shared by the expert-grouping dispatcher.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MOE_ROUTE_GROUP_BY_EXPERT_DEFINES_SVH
`define MOE_ROUTE_GROUP_BY_EXPERT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRGBE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MRGBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mrgbe_pkg.sv
// Shared types, constants and the reciprocal table of the expert-grouping dispatcher.
// No dependencies.
`timescale 1ns / 1ps

package mrgbe_pkg;

    localparam int TOKEN_W    = 3;
    localparam int WEIGHT_W   = 32;
    localparam int LOCAL_W    = 5;
    localparam int COUNT_W    = 7;
    localparam int DISTINCT_W = 6;
    localparam int PAIR_W     = TOKEN_W + WEIGHT_W;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CARD  = 2'd0;
    localparam logic [1:0] CFG_LAYER = 2'd1;
    localparam logic [1:0] CFG_TOPK  = 2'd2;
    localparam logic [1:0] CFG_ROWS  = 2'd3;

    // Decision for one accepted word.
    typedef struct packed {
        logic                  keep;
        logic [LOCAL_W-1:0]    local_idx;
        logic [TOKEN_W-1:0]    token;
        logic [COUNT_W-1:0]    item_next;
        logic                  batch_end;
    } admit_t;

    // ceil(1024 / k): multiplying a count below 128 by this and dropping ten bits
    // gives the exact quotient for every k from 1 to 8.
    function automatic logic [10:0] recip_k(input logic [3:0] k);
        logic [10:0] r;
        begin
            case (k)
                4'd1:    r = 11'd1024;
                4'd2:    r = 11'd512;
                4'd3:    r = 11'd342;
                4'd4:    r = 11'd256;
                4'd5:    r = 11'd205;
                4'd6:    r = 11'd171;
                4'd7:    r = 11'd147;
                4'd8:    r = 11'd128;
                default: r = 11'd1024;
            endcase
            return r;
        end
    endfunction

endpackage

>>> sv/mrgbe_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module mrgbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/mrgbe_admit.sv
// Keep decision, local expert, token row and batch-end test for one incoming word.
// Depends on mrgbe_pkg.
`timescale 1ns / 1ps

module mrgbe_admit
    import mrgbe_pkg::*;
#(
    parameter int MAX_ROWS         = 8,
    parameter int MAX_TOPK         = 8,
    parameter int EXPERTS_PER_CARD = 32,
    parameter int CARD_COUNT       = 4,
    parameter int PAIR_DEPTH       = 64
) (
    input  logic signed [7:0]   expert_id,
    input  logic [1:0]          card_index,
    input  logic [3:0]          top_k,
    input  logic [3:0]          row_count,
    input  logic [COUNT_W-1:0]  item_cnt,
    input  logic [COUNT_W-1:0]  kept_cnt,
    output admit_t              adm
);

    logic [3:0]  k_eff;
    logic [3:0]  r_eff;
    logic [7:0]  total;
    logic [17:0] prod;
    logic [7:0]  id_val;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        card_ok;
    logic        in_range;
    logic        room;

    always_comb
    begin
        if (top_k == 4'd0)
            k_eff = 4'd1;
        else if (top_k > 4'(MAX_TOPK))
            k_eff = 4'(MAX_TOPK);
        else
            k_eff = top_k;

        if (row_count == 4'd0)
            r_eff = 4'd1;
        else if (row_count > 4'(MAX_ROWS))
            r_eff = 4'(MAX_ROWS);
        else
            r_eff = row_count;
    end

    assign total = 8'(k_eff) * 8'(r_eff);

    // Token row is the item count divided by the choices per row.
    assign prod = 18'(item_cnt) * 18'(recip_k(k_eff));

    // The card owns ids from card * experts-per-card up to one block further.
    assign id_val   = {1'b0, expert_id[6:0]};
    assign lo       = 8'(card_index) * 8'(EXPERTS_PER_CARD);
    assign hi       = lo + 8'(EXPERTS_PER_CARD);
    assign card_ok  = 3'(card_index) < 3'(CARD_COUNT);
    assign in_range = (id_val >= lo) && (id_val < hi);
    assign room     = {1'b0, kept_cnt} < 8'(PAIR_DEPTH);

    always_comb
    begin
        adm.keep      = !expert_id[7] && card_ok && in_range && room;
        adm.local_idx = LOCAL_W'(id_val - lo);
        adm.token     = prod[10 +: TOKEN_W];
        adm.item_next = item_cnt + COUNT_W'(1);
        adm.batch_end = {1'b0, adm.item_next} >= total;
    end

endmodule

>>> sv/moe_route_group_by_expert.sv
// An input word is accepted in idle and then passes through the link state (busy is high
// there); the last word of a batch then starts the grouped emit. Emit reads each expert
// group's order entry and head pair, then walks that group's list of kept pairs; an empty
// batch shows its single result in the cycle straight after the last word's link cycle.
// Results cannot be stalled.
// Reset clears the configuration to card 0, layer 0, top_k 8, rows 8 and empties the batch.
`timescale 1ns / 1ps

// Expert-grouping dispatcher: top level with the batch sequencer and its four RAMs.
// Depends on mrgbe_pkg, mrgbe_ram, mrgbe_admit and moe_route_group_by_expert_defines.svh.
`include "moe_route_group_by_expert_defines.svh"

module moe_route_group_by_expert
    import mrgbe_pkg::*;
#(
    parameter int MAX_ROWS         = 8,
    parameter int MAX_TOPK         = 8,
    parameter int EXPERTS_PER_CARD = 32,
    parameter int CARD_COUNT       = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // Command channel.
    input  logic                    start,
    output logic                    busy,
    input  logic signed [7:0]       expert_id,
    input  logic [WEIGHT_W-1:0]     weight_bits,
    // Configuration write port.
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [5:0]              cfg_data,
    // Results.
    output logic                    result_strobe,
    output logic                    pair_valid,
    output logic [5:0]              pair_position,
    output logic [TOKEN_W-1:0]      token_index,
    output logic [WEIGHT_W-1:0]     pair_weight,
    output logic [5:0]              group_index,
    output logic                    group_first,
    output logic                    group_last,
    output logic [10:0]             expert_slot,
    output logic [COUNT_W-1:0]      expert_count,
    output logic [COUNT_W-1:0]      pair_count,
    output logic                    last
);

    // The pair store holds one word per kept choice; its depth is the largest batch.
    localparam int PAIR_DEPTH = MAX_ROWS * MAX_TOPK;
    localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int LW         = $clog2(EXPERTS_PER_CARD);
    localparam int ORDER_W    = PAIR_AW + LW;

    // The block keeps every expert's pairs as a linked list threaded through the pair
    // store. Per expert a tail RAM remembers the latest pair, and the order RAM lists
    // experts by first appearance together with the head pair of their list. When a word
    // of an already seen expert arrives, the tail is read in the accept cycle and the link
    // from the old tail is written in the following cycle; every word passes through the
    // link state before the next is accepted, so no forwarding is needed. At batch end the
    // sequencer reads each group from the order RAM and follows its list one pair per
    // cycle; a pair is the last of its group when it equals the expert's tail.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FIX  = 5'b00010,
        S_ORD  = 5'b00100,
        S_HEAD = 5'b01000,
        S_WALK = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic [1:0] card_reg;
    logic [5:0] layer_reg;
    logic [3:0] topk_reg;
    logic [3:0] rows_reg;

    // Batch state.
    logic [COUNT_W-1:0]          item_cnt_reg,   item_cnt_next;
    logic [COUNT_W-1:0]          kept_cnt_reg,   kept_cnt_next;
    logic [DISTINCT_W-1:0]       distinct_reg,   distinct_next;
    logic [EXPERTS_PER_CARD-1:0] seen_reg,       seen_next;
    logic                        batch_end_reg,  batch_end_next;
    logic                        fix_reg,        fix_next;
    logic [PAIR_AW-1:0]          fix_idx_reg,    fix_idx_next;
    logic [LW-1:0]               fix_local_reg,  fix_local_next;

    // Emit state.
    logic [5:0]                  group_reg,      group_next;
    logic [5:0]                  pos_reg,        pos_next;
    logic [PAIR_AW-1:0]          walk_ptr_reg,   walk_ptr_next;
    logic [LW-1:0]               grp_local_reg,  grp_local_next;
    logic                        first_reg,      first_next;

    // Result registers.
    logic                        strobe_reg,     strobe_next;
    logic                        pvalid_reg,     pvalid_next;
    logic [5:0]                  position_reg,   position_next;
    logic [TOKEN_W-1:0]          token_reg,      token_next;
    logic [WEIGHT_W-1:0]         weight_reg,     weight_next;
    logic [5:0]                  gindex_reg,     gindex_next;
    logic                        gfirst_reg,     gfirst_next;
    logic                        glast_reg,      glast_next;
    logic [10:0]                 slot_reg,       slot_next;
    logic [COUNT_W-1:0]          ecount_reg,     ecount_next;
    logic [COUNT_W-1:0]          pcount_reg,     pcount_next;
    logic                        last_reg,       last_next;

    // RAM ports.
    logic               pair_wr_en, pair_rd_en;
    logic [PAIR_AW-1:0] pair_wr_addr, pair_rd_addr;
    logic [PAIR_W-1:0]  pair_wr_data, pair_rd_data;
    logic               link_wr_en, link_rd_en;
    logic [PAIR_AW-1:0] link_wr_addr, link_rd_addr;
    logic [PAIR_AW-1:0] link_wr_data, link_rd_data;
    logic               tail_wr_en, tail_rd_en;
    logic [LW-1:0]      tail_wr_addr, tail_rd_addr;
    logic [PAIR_AW-1:0] tail_wr_data, tail_rd_data;
    logic               order_wr_en, order_rd_en;
    logic [LW-1:0]      order_wr_addr, order_rd_addr;
    logic [ORDER_W-1:0] order_wr_data, order_rd_data;

    admit_t             adm;
    logic [LW-1:0]      adm_local;
    logic               accept;
    logic               glast;
    logic               fin;

    mrgbe_admit #(
        .MAX_ROWS         (MAX_ROWS),
        .MAX_TOPK         (MAX_TOPK),
        .EXPERTS_PER_CARD (EXPERTS_PER_CARD),
        .CARD_COUNT       (CARD_COUNT),
        .PAIR_DEPTH       (PAIR_DEPTH)
    ) u_admit (
        .expert_id  (expert_id),
        .card_index (card_reg),
        .top_k      (topk_reg),
        .row_count  (rows_reg),
        .item_cnt   (item_cnt_reg),
        .kept_cnt   (kept_cnt_reg),
        .adm        (adm)
    );

    mrgbe_ram #(.WIDTH(PAIR_W), .DEPTH(PAIR_DEPTH)) u_pair_ram (
        .clk     (clk),
        .wr_en   (pair_wr_en),
        .wr_addr (pair_wr_addr),
        .wr_data (pair_wr_data),
        .rd_en   (pair_rd_en),
        .rd_addr (pair_rd_addr),
        .rd_data (pair_rd_data)
    );

    mrgbe_ram #(.WIDTH(PAIR_AW), .DEPTH(PAIR_DEPTH)) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    mrgbe_ram #(.WIDTH(PAIR_AW), .DEPTH(EXPERTS_PER_CARD)) u_tail_ram (
        .clk     (clk),
        .wr_en   (tail_wr_en),
        .wr_addr (tail_wr_addr),
        .wr_data (tail_wr_data),
        .rd_en   (tail_rd_en),
        .rd_addr (tail_rd_addr),
        .rd_data (tail_rd_data)
    );

    mrgbe_ram #(.WIDTH(ORDER_W), .DEPTH(EXPERTS_PER_CARD)) u_order_ram (
        .clk     (clk),
        .wr_en   (order_wr_en),
        .wr_addr (order_wr_addr),
        .wr_data (order_wr_data),
        .rd_en   (order_rd_en),
        .rd_addr (order_rd_addr),
        .rd_data (order_rd_data)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign adm_local = adm.local_idx[LW-1:0];

    // During the walk: the pair just read closes its group when it is the expert's tail,
    // and closes the batch when its position is the last of the kept pairs.
    assign glast = (walk_ptr_reg == tail_rd_data);
    assign fin   = ({1'b0, pos_reg} + COUNT_W'(1)) == kept_cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_cnt_next  = item_cnt_reg;
        kept_cnt_next  = kept_cnt_reg;
        distinct_next  = distinct_reg;
        seen_next      = seen_reg;
        batch_end_next = batch_end_reg;
        fix_next       = fix_reg;
        fix_idx_next   = fix_idx_reg;
        fix_local_next = fix_local_reg;
        group_next     = group_reg;
        pos_next       = pos_reg;
        walk_ptr_next  = walk_ptr_reg;
        grp_local_next = grp_local_reg;
        first_next     = first_reg;

        strobe_next    = 1'b0;
        pvalid_next    = pvalid_reg;
        position_next  = position_reg;
        token_next     = token_reg;
        weight_next    = weight_reg;
        gindex_next    = gindex_reg;
        gfirst_next    = gfirst_reg;
        glast_next     = glast_reg;
        slot_next      = slot_reg;
        ecount_next    = ecount_reg;
        pcount_next    = pcount_reg;
        last_next      = last_reg;

        pair_wr_en    = 1'b0;
        pair_wr_addr  = kept_cnt_reg[PAIR_AW-1:0];
        pair_wr_data  = {adm.token, weight_bits};
        pair_rd_en    = 1'b0;
        pair_rd_addr  = walk_ptr_reg;
        link_wr_en    = 1'b0;
        link_wr_addr  = tail_rd_data;
        link_wr_data  = fix_idx_reg;
        link_rd_en    = 1'b0;
        link_rd_addr  = walk_ptr_reg;
        tail_wr_en    = 1'b0;
        tail_wr_addr  = adm_local;
        tail_wr_data  = kept_cnt_reg[PAIR_AW-1:0];
        tail_rd_en    = 1'b0;
        tail_rd_addr  = adm_local;
        order_wr_en   = 1'b0;
        order_wr_addr = distinct_reg[LW-1:0];
        order_wr_data = {kept_cnt_reg[PAIR_AW-1:0], adm_local};
        order_rd_en   = 1'b0;
        order_rd_addr = group_reg[LW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fix_next       = 1'b0;
                    fix_idx_next   = kept_cnt_reg[PAIR_AW-1:0];
                    fix_local_next = adm_local;
                    item_cnt_next  = adm.item_next;
                    batch_end_next = adm.batch_end;
                    if (adm.keep)
                    begin
                        pair_wr_en    = 1'b1;
                        kept_cnt_next = kept_cnt_reg + COUNT_W'(1);
                        if (!seen_reg[adm_local])
                        begin
                            // First pair of this expert: open a new group.
                            order_wr_en          = 1'b1;
                            tail_wr_en           = 1'b1;
                            seen_next[adm_local] = 1'b1;
                            distinct_next        = distinct_reg + DISTINCT_W'(1);
                        end
                        else
                        begin
                            // Known expert: fetch its tail, link it next cycle.
                            tail_rd_en = 1'b1;
                            fix_next   = 1'b1;
                        end
                    end
                    state_next = S_FIX;
                end
            end

            S_FIX:
            begin
                if (fix_reg)
                begin
                    link_wr_en   = 1'b1;
                    tail_wr_en   = 1'b1;
                    tail_wr_addr = fix_local_reg;
                    tail_wr_data = fix_idx_reg;
                end
                if (!batch_end_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (kept_cnt_reg == COUNT_W'(0))
                begin
                    // Nothing kept: one empty result closes the batch.
                    strobe_next   = 1'b1;
                    pvalid_next   = 1'b0;
                    position_next = '0;
                    token_next    = '0;
                    weight_next   = '0;
                    gindex_next   = '0;
                    gfirst_next   = 1'b0;
                    glast_next    = 1'b0;
                    slot_next     = '0;
                    ecount_next   = '0;
                    pcount_next   = '0;
                    last_next     = 1'b1;
                    item_cnt_next = '0;
                    distinct_next = '0;
                    seen_next     = '0;
                    group_next    = '0;
                    pos_next      = '0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_ORD;
                end
            end

            S_ORD:
            begin
                order_rd_en = 1'b1;
                state_next  = S_HEAD;
            end

            S_HEAD:
            begin
                grp_local_next = order_rd_data[LW-1:0];
                walk_ptr_next  = order_rd_data[ORDER_W-1:LW];
                pair_rd_en     = 1'b1;
                pair_rd_addr   = order_rd_data[ORDER_W-1:LW];
                link_rd_en     = 1'b1;
                link_rd_addr   = order_rd_data[ORDER_W-1:LW];
                tail_rd_en     = 1'b1;
                tail_rd_addr   = order_rd_data[LW-1:0];
                first_next     = 1'b1;
                state_next     = S_WALK;
            end

            S_WALK:
            begin
                strobe_next   = 1'b1;
                pvalid_next   = 1'b1;
                position_next = pos_reg;
                token_next    = pair_rd_data[PAIR_W-1:WEIGHT_W];
                weight_next   = pair_rd_data[WEIGHT_W-1:0];
                gindex_next   = group_reg;
                gfirst_next   = first_reg;
                glast_next    = glast;
                slot_next     = 11'(11'(layer_reg) * 11'(EXPERTS_PER_CARD)
                                    + 11'(grp_local_reg));
                ecount_next   = fin ? COUNT_W'(distinct_reg) : '0;
                pcount_next   = fin ? kept_cnt_reg : '0;
                last_next     = fin;
                pos_next      = pos_reg + 6'd1;
                first_next    = 1'b0;
                if (glast)
                begin
                    group_next = group_reg + 6'd1;
                    if (fin)
                    begin
                        item_cnt_next = '0;
                        kept_cnt_next = '0;
                        distinct_next = '0;
                        seen_next     = '0;
                        group_next    = '0;
                        pos_next      = '0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ORD;
                    end
                end
                else
                begin
                    walk_ptr_next = link_rd_data;
                    pair_rd_en    = 1'b1;
                    pair_rd_addr  = link_rd_data;
                    link_rd_en    = 1'b1;
                    link_rd_addr  = link_rd_data;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration registers; an index with no register behind it is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            card_reg  <= 2'd0;
            layer_reg <= 6'd0;
            topk_reg  <= 4'd8;
            rows_reg  <= 4'd8;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CARD:  card_reg  <= cfg_data[1:0];
                CFG_LAYER: layer_reg <= cfg_data[5:0];
                CFG_TOPK:  topk_reg  <= cfg_data[3:0];
                CFG_ROWS:  rows_reg  <= cfg_data[3:0];
                default:   card_reg  <= card_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_cnt_reg  <= '0;
            kept_cnt_reg  <= '0;
            distinct_reg  <= '0;
            seen_reg      <= '0;
            batch_end_reg <= 1'b0;
            fix_reg       <= 1'b0;
            group_reg     <= '0;
            pos_reg       <= '0;
            first_reg     <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            item_cnt_reg  <= item_cnt_next;
            kept_cnt_reg  <= kept_cnt_next;
            distinct_reg  <= distinct_next;
            seen_reg      <= seen_next;
            batch_end_reg <= batch_end_next;
            fix_reg       <= fix_next;
            group_reg     <= group_next;
            pos_reg       <= pos_next;
            first_reg     <= first_next;
            strobe_reg    <= strobe_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        fix_idx_reg   <= fix_idx_next;
        fix_local_reg <= fix_local_next;
        walk_ptr_reg  <= walk_ptr_next;
        grp_local_reg <= grp_local_next;
        pvalid_reg    <= pvalid_next;
        position_reg  <= position_next;
        token_reg     <= token_next;
        weight_reg    <= weight_next;
        gindex_reg    <= gindex_next;
        gfirst_reg    <= gfirst_next;
        glast_reg     <= glast_next;
        slot_reg      <= slot_next;
        ecount_reg    <= ecount_next;
        pcount_reg    <= pcount_next;
        last_reg      <= last_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign pair_valid    = pvalid_reg;
    assign pair_position = position_reg;
    assign token_index   = token_reg;
    assign pair_weight   = weight_reg;
    assign group_index   = gindex_reg;
    assign group_first   = gfirst_reg;
    assign group_last    = glast_reg;
    assign expert_slot   = slot_reg;
    assign expert_count  = ecount_reg;
    assign pair_count    = pcount_reg;
    assign last          = last_reg;

    // Every accepted word holds the block for its link cycle.
    `MRGBE_ASSERT_NEXT(a_accept_then_busy, start && !busy, busy, "accepted word did not raise busy")
    // Totals appear on the closing word of a batch only.
    `MRGBE_ASSERT_NOW(a_totals_only_last, result_strobe && !last, (pair_count == '0) && (expert_count == '0), "totals shown before batch end")
    // The empty result is always the closing one.
    `MRGBE_ASSERT_NOW(a_empty_is_last, result_strobe && !pair_valid, last, "empty result not marked last")
    // The closing pair must also close its group.
    `MRGBE_ASSERT_NOW(a_last_closes_group, result_strobe && pair_valid && last, group_last, "batch ended inside a group")
    // The pair store never overflows.
    `MRGBE_ASSERT_NOW(a_kept_bound, 1'b1, kept_cnt_reg <= COUNT_W'(PAIR_DEPTH), "pair store overflow")

endmodule
